/* design/sbe_pkg.sv */
// Shared widths, reset value and flag bundle of the subset enumerator.
package sbe_pkg;

	// Width of the subset mask and entry number ports
	localparam int unsigned PORT_W = 31;
	// Width of the element count and subset size fields
	localparam int unsigned SIZE_W = 5;
	// Element count after reset
	localparam logic [SIZE_W-1:0] ELEM_RESET = 5'd16;

	// Per-entry markers that travel with each mask
	typedef struct packed {
		logic first;
		logic last;
	} flags_t;

endpackage

/* design/sbe_step.sv */
// Successor logic: derives the next mask, size, count and markers from the held state.
module sbe_step #(
	parameter int unsigned MAX_ELEMENTS = 31
) (
	input  logic [MAX_ELEMENTS-1:0]        mask,
	input  logic [sbe_pkg::SIZE_W-1:0]     size,
	input  logic [MAX_ELEMENTS-1:0]        count,
	input  logic [sbe_pkg::SIZE_W-1:0]     elem_count,
	input  logic                           restart,
	output logic [MAX_ELEMENTS-1:0]        mask_nxt,
	output logic [sbe_pkg::SIZE_W-1:0]     size_nxt,
	output logic [MAX_ELEMENTS-1:0]        count_nxt,
	output sbe_pkg::flags_t                flags_nxt
);

	localparam int unsigned W = MAX_ELEMENTS;
	localparam logic [sbe_pkg::SIZE_W-1:0] MAX_N = sbe_pkg::SIZE_W'(MAX_ELEMENTS);
	localparam logic [W-1:0] ONES = {W{1'b1}};
	localparam logic [W-1:0] ONE = W'(1);

	logic [sbe_pkg::SIZE_W-1:0] n;
	logic [sbe_pkg::SIZE_W-1:0] size_inc;
	logic [sbe_pkg::SIZE_W-1:0] t;
	logic [W-1:0] full;
	logic [W-1:0] m_inc;
	logic [W-1:0] low_zero;
	logic [W-1:0] cleared;
	logic [W-1:0] pivot;
	logic [W-1:0] below;
	logic [W-1:0] block;
	logic [W-1:0] same_size;
	logic [W-1:0] low_fill;
	logic [W-1:0] grown;
	logic [W-1:0] first_mask;
	logic bad;
	logic at_low;

	// Clamp the element count into 1..MAX_ELEMENTS
	always_comb begin
		if (elem_count == '0) begin
			n = sbe_pkg::SIZE_W'(1);
		end else if (elem_count > MAX_N) begin
			n = MAX_N;
		end else begin
			n = elem_count;
		end
	end

	assign full = ~(ONES << n);
	assign first_mask = ONE << (n - sbe_pkg::SIZE_W'(1));

	// Held state unusable: not started, finished, or bits beyond the set
	assign bad = (mask == '0) || ((mask & ~full) != '0) || (mask == full);

	// Locate the trailing ones and the one bit above them
	assign m_inc    = mask + ONE;
	assign low_zero = ~mask & m_inc;
	assign cleared  = mask & m_inc;
	assign pivot    = cleared & (~cleared + ONE);
	assign below    = pivot - ONE;

	// Encode the trailing-ones count from the one-hot lowest zero
	always_comb begin
		t = '0;
		for (int i = 0; i < W; i++) begin
			if (low_zero[i]) begin
				t = t | sbe_pkg::SIZE_W'(i);
			end
		end
	end

	// Pack trailing ones plus one directly under the pivot bit
	assign block     = below & ~((below >> 1) >> t);
	assign same_size = (cleared & ~pivot) | block;

	// Group change: top size+1 bits set
	assign low_fill = ~(ONES << size);
	assign at_low   = (mask == low_fill);
	assign size_inc = size + sbe_pkg::SIZE_W'(1);
	assign grown    = (~(ONES << size_inc)) << (n - size_inc);

	// Select the successor
	always_comb begin
		if (restart || bad) begin
			mask_nxt        = first_mask;
			size_nxt        = sbe_pkg::SIZE_W'(1);
			count_nxt       = '0;
			flags_nxt.first = 1'b1;
		end else if (at_low) begin
			mask_nxt        = grown;
			size_nxt        = size_inc;
			count_nxt       = count + ONE;
			flags_nxt.first = 1'b1;
		end else begin
			mask_nxt        = same_size;
			size_nxt        = size;
			count_nxt       = count + ONE;
			flags_nxt.first = 1'b0;
		end
		flags_nxt.last = (mask_nxt == full);
	end

endmodule

/* design/subset_bitmask_enumerator_by_size_unit.sv */
// Top level of the subset enumerator: state, result register and handshakes.
//
// Each transfer on the input channel (in_valid/in_ready, field restart)
// yields exactly one result on the output channel (out_valid/out_ready):
// the next non-empty subset mask, its size, its entry number and the
// first_of_size and final_entry markers. restart high returns to the first
// subset (bit N-1 alone); after the all-ones mask the sequence wraps.
// The result is held in the output register in the cycle after the input
// transfer. A new item is taken in every cycle while the output register is
// empty or being drained, so the rate is one item per cycle; the successor
// search (trailing ones, next one bit, repack) is the path between state
// and result register.
// When the receiver stalls, the result holds and in_ready drops until the
// result is taken. The element_count register is written through its own
// channel (cfg_valid/cfg_ready) and takes effect on the next item.
// Reset clears the state to not-started and sets element_count to 16; the
// first item after reset gives the first subset whatever restart says.
module subset_bitmask_enumerator_by_size_unit #(
	parameter int unsigned MAX_ELEMENTS = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sbe_pkg::SIZE_W-1:0]      element_count,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sbe_pkg::PORT_W-1:0]      subset_mask,
	output logic [sbe_pkg::SIZE_W-1:0]      subset_size,
	output logic [sbe_pkg::PORT_W-1:0]      entry_number,
	output logic                            first_of_size,
	output logic                            final_entry
);

	localparam int unsigned W = MAX_ELEMENTS;

	logic [sbe_pkg::SIZE_W-1:0] elem_q;
	logic [W-1:0]               mask_q;
	logic [sbe_pkg::SIZE_W-1:0] size_q;
	logic [W-1:0]               count_q;
	sbe_pkg::flags_t            flags_q;
	logic                       out_valid_q;

	logic [W-1:0]               mask_nxt;
	logic [sbe_pkg::SIZE_W-1:0] size_nxt;
	logic [W-1:0]               count_nxt;
	sbe_pkg::flags_t            flags_nxt;
	logic                       in_xfer;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q <= sbe_pkg::ELEM_RESET;
		end else if (cfg_valid) begin
			elem_q <= element_count;
		end
	end

	// Successor of the held state
	sbe_step #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_step (
		.mask      (mask_q),
		.size      (size_q),
		.count     (count_q),
		.elem_count(elem_q),
		.restart   (restart),
		.mask_nxt  (mask_nxt),
		.size_nxt  (size_nxt),
		.count_nxt (count_nxt),
		.flags_nxt (flags_nxt)
	);

	// Accept while the result slot is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// Advance state; the state registers double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			size_q      <= '0;
			count_q     <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				mask_q  <= mask_nxt;
				size_q  <= size_nxt;
				count_q <= count_nxt;
				flags_q <= flags_nxt;
			end
			if (in_xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Drive the result ports
	assign out_valid     = out_valid_q;
	assign subset_mask   = sbe_pkg::PORT_W'(mask_q);
	assign subset_size   = size_q;
	assign entry_number  = sbe_pkg::PORT_W'(count_q);
	assign first_of_size = flags_q.first;
	assign final_entry   = flags_q.last;

`ifndef NO_ASSERTIONS
	// Held mask always carries as many ones as its size
	a_size_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones(mask_q) == 32'(size_q)))
		else $error("subset size does not match mask popcount");

	// Entry zero opens the size-one group
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && count_q == '0) |-> (flags_q.first && size_q == 5'd1))
		else $error("entry zero is not the first single-element subset");

	// A restart transfer yields entry zero
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && restart) |=> (out_valid_q && count_q == '0))
		else $error("restart did not return to entry zero");

	// A stalled result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(mask_q) && $stable(count_q)))
		else $error("stalled result changed");
`endif

endmodule

/* tb/subset_bitmask_enumerator_by_size_unit_tb.sv */
// Self-checking testbench for the subset enumerator: directed and random runs against a predictor.
module subset_bitmask_enumerator_by_size_unit_tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_ITEMS = 950;

	// One result as the block should present it
	typedef struct packed {
		logic [sbe_pkg::PORT_W-1:0] mask;
		logic [sbe_pkg::SIZE_W-1:0] size;
		logic [sbe_pkg::PORT_W-1:0] entry;
		sbe_pkg::flags_t            flags;
	} subset_entry_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [sbe_pkg::SIZE_W-1:0] element_count = sbe_pkg::ELEM_RESET;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       restart = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [sbe_pkg::PORT_W-1:0] subset_mask;
	logic [sbe_pkg::SIZE_W-1:0] subset_size;
	logic [sbe_pkg::PORT_W-1:0] entry_number;
	logic                       first_of_size;
	logic                       final_entry;

	// Predictor copy of the register and the enumeration state
	logic [sbe_pkg::SIZE_W-1:0] elem_reg = sbe_pkg::ELEM_RESET;
	logic [31:0]                held_mask = '0;
	logic [sbe_pkg::SIZE_W-1:0] held_size = '0;
	logic [sbe_pkg::PORT_W-1:0] held_count = '0;

	subset_entry_t     pending_subsets[$];
	int unsigned       mismatch_count = 0;
	int unsigned       cycle_count = 0;
	int unsigned       items_sent = 0;
	logic              steady = 1'b0;

	subset_bitmask_enumerator_by_size_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.element_count (element_count),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.subset_mask   (subset_mask),
		.subset_size   (subset_size),
		.entry_number  (entry_number),
		.first_of_size (first_of_size),
		.final_entry   (final_entry)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hold reset at the start, then release it for good
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver back-pressure: stall about a third of the cycles unless running steady
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 33);
	end

	// Work out the next subset and advance the predictor state
	function automatic subset_entry_t next_subset(input logic from_start);
		int            n;
		int            t;
		int            hi;
		logic [31:0]   full;
		logic [31:0]   m;
		logic          broken;
		logic          opens;
		subset_entry_t e;
		n = (elem_reg == 0) ? 1 : int'(elem_reg);
		full = (32'd1 << n) - 32'd1;
		broken = held_mask == 0 || (held_mask & ~full) != 0 ||
			$countones(held_mask) != int'(held_size) || held_size == 0 ||
			held_mask == full;
		opens = 1'b0;
		if (from_start || broken) begin
			held_size = 1;
			held_mask = 32'd1 << (n - 1);
			held_count = '0;
			opens = 1'b1;
		end else begin
			if (held_mask == (32'd1 << held_size) - 32'd1) begin
				// group exhausted: open the next size at the top bits
				held_size = held_size + 1'b1;
				held_mask = ((32'd1 << held_size) - 32'd1) << (n - int'(held_size));
				opens = 1'b1;
			end else begin
				// clear the one above the trailing ones and pack them just below it
				t = 0;
				while (t < 31 && held_mask[t]) t++;
				hi = t + 1;
				while (hi < 31 && !held_mask[hi]) hi++;
				if (hi < 31) begin
					m = held_mask & ~((32'd1 << (hi + 1)) - 32'd1);
					m |= ((32'd1 << (t + 1)) - 32'd1) << (hi - 1 - t);
					held_mask = m;
				end
			end
			held_count = held_count + 1'b1;
		end
		e.mask = held_mask[sbe_pkg::PORT_W-1:0];
		e.size = held_size;
		e.entry = held_count;
		e.flags.first = opens;
		e.flags.last = (held_mask == full);
		return e;
	endfunction

	// Offer one item and record its expected subset on transfer
	task automatic send_item(input logic from_start);
		if (!steady && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= from_start;
		do @(posedge clk); while (!in_ready);
		pending_subsets.push_back(next_subset(from_start));
		items_sent++;
	endtask

	// Drain all results, then write the element count while idle
	task automatic write_element_count(input logic [sbe_pkg::SIZE_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_subsets.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		element_count <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		elem_reg = value;
	endtask

	task automatic check_field(input string what, input logic [sbe_pkg::PORT_W-1:0] want,
			input logic [sbe_pkg::PORT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		subset_entry_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_subsets.size() == 0) begin
				$display("%0t: unexpected result, expected none got mask %0h",
					$time, subset_mask);
				mismatch_count++;
			end else begin
				want = pending_subsets.pop_front();
				check_field("subset_mask", want.mask, subset_mask);
				check_field("subset_size", sbe_pkg::PORT_W'(want.size),
					sbe_pkg::PORT_W'(subset_size));
				check_field("entry_number", want.entry, entry_number);
				check_field("first_of_size", sbe_pkg::PORT_W'(want.flags.first),
					sbe_pkg::PORT_W'(first_of_size));
				check_field("final_entry", sbe_pkg::PORT_W'(want.flags.last),
					sbe_pkg::PORT_W'(final_entry));
			end
		end
	end

	// Default count after reset: first item starts whatever restart says
	task automatic test_reset_start();
		send_item(1'b0);
		send_item(1'b0);
		send_item(1'b1);
	endtask

	// Single element gives a first entry that is also final; two elements wrap after three
	task automatic test_small_sets();
		write_element_count(5'd1);
		send_item(1'b0);
		send_item(1'b0);
		write_element_count(5'd2);
		repeat (4) send_item(1'b0);
	endtask

	// Zero count behaves as one element
	task automatic test_zero_count();
		write_element_count(5'd0);
		send_item(1'b0);
		send_item(1'b0);
	endtask

	// Widest mask
	task automatic test_widest();
		write_element_count(5'd31);
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b0);
	endtask

	// Count change mid-sequence: stray high bits restart, a consistent mask carries on
	task automatic test_count_change();
		write_element_count(5'd5);
		repeat (3) send_item(1'b0);
		write_element_count(5'd3);
		repeat (6) send_item(1'b0);
		write_element_count(5'd5);
		send_item(1'b0);
	endtask

	// Long stretch with neither side idling
	task automatic test_back_to_back();
		steady = 1'b1;
		write_element_count(5'd4);
		repeat (60) send_item($urandom_range(0, 99) < 3);
		in_valid <= 1'b0;
		while (pending_subsets.size() != 0) @(posedge clk);
		steady = 1'b0;
	endtask

	// Random phases, mostly small sets so that whole sequences wrap
	task automatic test_random_phases();
		int unsigned pick;
		int unsigned phase_items;
		logic [sbe_pkg::SIZE_W-1:0] count;
		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) count = sbe_pkg::SIZE_W'($urandom_range(1, 6));
			else if (pick < 90) count = sbe_pkg::SIZE_W'($urandom_range(7, 10));
			else if (pick < 95) count = '0;
			else count = sbe_pkg::SIZE_W'($urandom_range(11, 31));
			write_element_count(count);
			phase_items = $urandom_range(10, 120);
			repeat (phase_items) send_item($urandom_range(0, 99) < 3);
		end
	endtask

	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		test_reset_start();
		test_small_sets();
		test_zero_count();
		test_widest();
		test_count_change();
		test_back_to_back();
		test_random_phases();
		// Let every outstanding result arrive, then settle
		in_valid <= 1'b0;
		while (pending_subsets.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
